// ===== rtl/kbs_pkg.sv =====
// Shared types, request codes and the per-key character table of the keyboard scanner.
package kbs_pkg;

    // Bus request codes
    localparam logic [2:0] REQ_STATUS_RD = 3'd0;
    localparam logic [2:0] REQ_CTRL_WR   = 3'd1;
    localparam logic [2:0] REQ_DATA_RD   = 3'd2;
    localparam logic [2:0] REQ_DATA_WR   = 3'd3;
    localparam logic [2:0] REQ_KEY       = 3'd4;

    // Key actions
    localparam logic [1:0] ACT_DOWN   = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;

    // Modifier bits (active low)
    localparam logic [3:0] MOD_SHIFT = 4'b0001;
    localparam logic [3:0] MOD_TOP   = 4'b0010;
    localparam logic [3:0] MOD_META  = 4'b0100;
    localparam logic [3:0] MOD_CTRL  = 4'b1000;

    // Data word bits
    localparam int unsigned WORD_TOP_BIT   = 7;
    localparam int unsigned WORD_VALID_BIT = 12;
    localparam int unsigned NUM_KEYS       = 54;

    // Special keys
    localparam logic [6:0] KEY_C         = 7'd12;
    localparam logic [6:0] KEY_BACKSLASH = 7'd43;

    // Control write bits
    localparam int unsigned CTRL_CLR_BIT = 3;
    localparam int unsigned SPW_SEL_BIT  = 12;

    // Status bits
    localparam int unsigned ST_DONE = 0;
    localparam int unsigned ST_SPW  = 1;

    typedef enum logic [1:0] {
        OP_KEEP = 2'd0,
        OP_CLR  = 2'd1,
        OP_SET  = 2'd2
    } top_op_t;

    typedef struct packed {
        logic [5:0] nc;
        top_op_t    nop;
        logic       has_alt;
        logic [5:0] ac;
        top_op_t    aop;
    } keymap_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [12:0] bus_data;
        logic [6:0]  key_code;
        logic [1:0]  key_action;
    } in_word_t;

    typedef struct packed {
        logic [23:0] read_data;
        logic        key_handled;
        logic        irq_pending;
        logic [2:0]  irq_level;
    } out_word_t;

    typedef struct packed {
        logic        handled;
        logic        word_we;
        logic [12:0] word;
        logic [3:0]  mods_next;
    } key_result_t;

    // Per-key character table: normal code/op and shift-only alternate
    function automatic keymap_t keymap_lookup(logic [6:0] key);
        keymap_t r;
        r = '{6'o00, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
        case (key) inside
            7'd0:  r = '{6'o60, OP_KEEP, 1'b1, 6'o51, OP_KEEP};
            7'd1:  r = '{6'o61, OP_KEEP, 1'b1, 6'o54, OP_CLR};
            7'd2:  r = '{6'o62, OP_KEEP, 1'b1, 6'o52, OP_CLR};
            7'd3:  r = '{6'o63, OP_KEEP, 1'b1, 6'o22, OP_CLR};
            7'd4:  r = '{6'o64, OP_KEEP, 1'b1, 6'o66, OP_CLR};
            7'd5:  r = '{6'o65, OP_KEEP, 1'b1, 6'o67, OP_CLR};
            7'd6:  r = '{6'o66, OP_KEEP, 1'b1, 6'o73, OP_CLR};
            7'd7:  r = '{6'o67, OP_KEEP, 1'b1, 6'o24, OP_CLR};
            7'd8:  r = '{6'o70, OP_KEEP, 1'b1, 6'o52, OP_CLR};
            7'd9:  r = '{6'o71, OP_KEEP, 1'b1, 6'o50, OP_KEEP};
            // letters A..Z map to codes 1..26
            [7'd10:7'd35]: r = '{key[5:0] - 6'd9, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd36: r = '{6'o00, OP_KEEP, 1'b1, 6'o43, OP_KEEP};
            7'd37: r = '{6'o55, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd38: r = '{6'o10, OP_CLR,  1'b1, 6'o53, OP_KEEP};
            7'd39: r = '{6'o50, OP_CLR,  1'b1, 6'o17, OP_CLR};
            7'd40: r = '{6'o51, OP_CLR,  1'b1, 6'o20, OP_CLR};
            7'd41: r = '{6'o73, OP_SET,  1'b1, 6'o72, OP_SET};
            7'd42: r = '{6'o11, OP_CLR,  1'b1, 6'o31, OP_CLR};
            7'd43: r = '{6'o34, OP_SET,  1'b1, 6'o53, OP_CLR};
            7'd44: r = '{6'o34, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd45: r = '{6'o54, OP_SET,  1'b1, 6'o04, OP_CLR};
            7'd46: r = '{6'o56, OP_KEEP, 1'b1, 6'o06, OP_CLR};
            7'd47: r = '{6'o57, OP_KEEP, 1'b1, 6'o56, OP_CLR};
            7'd48: r = '{6'o42, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd49: r = '{6'o74, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd50: r = '{6'o44, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd51: r = '{6'o45, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd52: r = '{6'o33, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            7'd53: r = '{6'o40, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
            default: r = '{6'o00, OP_KEEP, 1'b0, 6'o00, OP_KEEP};
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/kbs_key_decode.sv =====
// Key event decode: modifier tracking and data word formation for mapped keys.
module kbs_key_decode (
    input  logic [6:0]          key_code,
    input  logic [1:0]          key_action,
    input  logic [3:0]          mods,
    output kbs_pkg::key_result_t result
);

    logic [3:0]       mod_mask;
    kbs_pkg::keymap_t km;
    logic             shift_only;
    logic [5:0]       code;
    kbs_pkg::top_op_t op;
    logic [12:0]      w;

    // Which modifier a key drives
    always_comb begin
        case (key_code) inside
            [7'd54:7'd56]: mod_mask = kbs_pkg::MOD_SHIFT;
            [7'd57:7'd58]: mod_mask = kbs_pkg::MOD_CTRL;
            [7'd59:7'd60]: mod_mask = kbs_pkg::MOD_META;
            [7'd61:7'd62]: mod_mask = kbs_pkg::MOD_TOP;
            default:       mod_mask = 4'b0000;
        endcase
    end

    assign km         = kbs_pkg::keymap_lookup(key_code);
    assign shift_only = ((mods & (kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT)) == kbs_pkg::MOD_TOP);

    // Character code and top-bit op, with the key-specific overrides
    always_comb begin
        code = km.nc;
        op   = km.nop;
        if (key_code == kbs_pkg::KEY_BACKSLASH) begin
            if (shift_only) begin
                code = 6'o53;
                op   = kbs_pkg::OP_CLR;
            end else if ((mods & (kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT))
                         == kbs_pkg::MOD_SHIFT) begin
                op = kbs_pkg::OP_CLR;
            end else begin
                op = kbs_pkg::OP_SET;
            end
        end else if (key_code == kbs_pkg::KEY_C) begin
            if (mods == (kbs_pkg::MOD_META | kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT)) begin
                code = 6'o43;
            end
        end else if (shift_only && km.has_alt) begin
            code = km.ac;
            op   = km.aop;
        end
    end

    // Word assembly
    always_comb begin
        w = {3'b000, mods, code};
        case (op)
            kbs_pkg::OP_CLR: w[kbs_pkg::WORD_TOP_BIT] = 1'b0;
            kbs_pkg::OP_SET: w[kbs_pkg::WORD_TOP_BIT] = 1'b1;
            default:         w[kbs_pkg::WORD_TOP_BIT] = w[kbs_pkg::WORD_TOP_BIT];
        endcase
        w[kbs_pkg::WORD_VALID_BIT] = 1'b1;
    end

    // Outcome of the event
    always_comb begin
        result.handled   = 1'b0;
        result.word_we   = 1'b0;
        result.word      = w;
        result.mods_next = mods;
        if (mod_mask != 4'b0000) begin
            if (key_action == kbs_pkg::ACT_UP) begin
                result.handled   = 1'b1;
                result.mods_next = mods | mod_mask;
            end else if (key_action == kbs_pkg::ACT_DOWN) begin
                result.handled   = 1'b1;
                result.mods_next = mods & ~mod_mask;
            end
        end else if (key_action != kbs_pkg::ACT_UP
                     && key_code < 7'(kbs_pkg::NUM_KEYS)) begin
            result.handled = 1'b1;
            result.word_we = 1'b1;
        end
    end

endmodule

// ===== rtl/keyboard_scanner_registers.sv =====
// Keyboard scanner register block: input register, state update and result register.
// A word passes from the input register to the result register, whose contents drive m_*.
// Throughput: one word per cycle; the result register frees the input side while a
// result waits, so s_ready drops only when both registers are full and m_ready is low.
// Reset (aresetn low, synchronous): modifiers all ones, data word, status, level,
// line and interrupt cleared, both pipeline registers empty.
module keyboard_scanner_registers (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kbs_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kbs_pkg::out_word_t m_data
);

    logic               in_valid_reg;
    kbs_pkg::in_word_t  in_reg;
    logic               out_valid_reg;
    kbs_pkg::out_word_t out_reg;
    kbs_pkg::out_word_t out_next;
    logic               advance;

    logic [3:0]  mods_reg,  mods_next;
    logic [12:0] word_reg,  word_next;
    logic [1:0]  status_reg, status_next;
    logic [2:0]  level_reg, level_next;
    logic [5:0]  line_reg,  line_next;
    logic        irq_reg,   irq_next;

    kbs_pkg::key_result_t key_res;

    // Handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    kbs_key_decode u_key_decode (
        .key_code   (in_reg.key_code),
        .key_action (in_reg.key_action),
        .mods       (mods_reg),
        .result     (key_res)
    );

    // Request execution
    always_comb begin
        mods_next   = mods_reg;
        word_next   = word_reg;
        status_next = status_reg;
        level_next  = level_reg;
        line_next   = line_reg;
        irq_next    = irq_reg;
        out_next    = '0;
        case (in_reg.req_type)
            kbs_pkg::REQ_STATUS_RD: begin
                out_next.read_data = {19'd0, status_reg, level_reg};
            end
            kbs_pkg::REQ_CTRL_WR: begin
                level_next = in_reg.bus_data[2:0];
                if (in_reg.bus_data[kbs_pkg::CTRL_CLR_BIT]) begin
                    status_next = 2'b00;
                end
                irq_next = 1'b0;
            end
            kbs_pkg::REQ_DATA_RD: begin
                out_next.read_data = {line_reg, 5'd0, word_reg};
                status_next        = 2'b00;
                irq_next           = 1'b0;
            end
            kbs_pkg::REQ_DATA_WR: begin
                if (in_reg.bus_data[kbs_pkg::SPW_SEL_BIT]) begin
                    status_next[kbs_pkg::ST_SPW] = 1'b1;
                    line_next = in_reg.bus_data[5:0];
                end
            end
            kbs_pkg::REQ_KEY: begin
                out_next.key_handled = key_res.handled;
                mods_next            = key_res.mods_next;
                if (key_res.word_we) begin
                    word_next                     = key_res.word;
                    status_next[kbs_pkg::ST_DONE] = 1'b1;
                    if (level_reg != 3'd0) begin
                        irq_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        out_next.irq_pending = irq_next;
        out_next.irq_level   = irq_next ? level_next : 3'd0;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mods_reg   <= 4'b1111;
            word_reg   <= '0;
            status_reg <= '0;
            level_reg  <= '0;
            line_reg   <= '0;
            irq_reg    <= 1'b0;
        end else if (advance) begin
            mods_reg   <= mods_next;
            word_reg   <= word_next;
            status_reg <= status_next;
            level_reg  <= level_next;
            line_reg   <= line_next;
            irq_reg    <= irq_next;
        end
    end

    // Checks
    a_irq_needs_level: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_reg |-> level_reg != 3'd0)
        else $error("interrupt raised at level zero");

    a_word_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        word_reg != 13'd0 |-> word_reg[kbs_pkg::WORD_VALID_BIT])
        else $error("data word stored without VALID");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_out_irq_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_data.irq_pending == irq_reg)
        else $error("result interrupt flag differs from state");

endmodule

// ===== verif/keyboard_scanner_registers_tb.sv =====
// Testbench for keyboard_scanner_registers: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module keyboard_scanner_registers_tb;

    localparam int IDLE_PCT     = 11;
    localparam int HOLD_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_WORDS = 1250;

    // Request and action codes the package leaves unnamed
    localparam logic [2:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [2:0] REQ_RSVD_MID = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI  = 3'd7;
    localparam logic [1:0] ACT_REPEAT   = 2'd2;
    localparam logic [1:0] ACT_ODD      = 2'd3;

    // Key numbers used by name
    localparam logic [6:0] KEY_DIGIT0   = 7'd0;
    localparam logic [6:0] KEY_DIGIT1   = 7'd1;
    localparam logic [6:0] KEY_DIGIT5   = 7'd5;
    localparam logic [6:0] KEY_A        = 7'd10;
    localparam logic [6:0] KEY_Z        = 7'd35;
    localparam logic [6:0] KEY_SHIFT_L  = 7'd54;
    localparam logic [6:0] KEY_SHIFT_R  = 7'd55;
    localparam logic [6:0] KEY_CAPS     = 7'd56;
    localparam logic [6:0] KEY_CTRL_L   = 7'd57;
    localparam logic [6:0] KEY_CTRL_R   = 7'd58;
    localparam logic [6:0] KEY_META_L   = 7'd59;
    localparam logic [6:0] KEY_META_R   = 7'd60;
    localparam logic [6:0] KEY_TOP_L    = 7'd61;
    localparam logic [6:0] KEY_TOP_R    = 7'd62;
    localparam logic [6:0] KEY_UNMAPPED = 7'd63;
    localparam logic [6:0] KEY_MAX      = 7'd127;

    // Character codes forced by the special keys
    localparam logic [5:0] CODE_C_CTRL    = 6'o43;
    localparam logic [5:0] CODE_BSL_SHIFT = 6'o53;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    kbs_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    kbs_pkg::out_word_t m_data;

    kbs_pkg::out_word_t pending_results[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    // Predicted register state of the scanner
    logic [3:0]  mods_q;
    logic [12:0] kword_q;
    logic [1:0]  status_q;
    logic [2:0]  level_q;
    logic [5:0]  line_q;
    logic        irq_q;

    keyboard_scanner_registers dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Character table: normal code and top op, then the shift-only alternate
    function automatic kbs_pkg::keymap_t char_entry(logic [6:0] k);
        kbs_pkg::keymap_t e;
        e = '{6'o00, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
        if (k >= KEY_A && k <= KEY_Z) begin
            e.nc = 6'(k - KEY_A + 7'd1);
        end else begin
            case (k)
                7'd0:  e = '{6'o60, kbs_pkg::OP_KEEP, 1'b1, 6'o51, kbs_pkg::OP_KEEP};
                7'd1:  e = '{6'o61, kbs_pkg::OP_KEEP, 1'b1, 6'o54, kbs_pkg::OP_CLR};
                7'd2:  e = '{6'o62, kbs_pkg::OP_KEEP, 1'b1, 6'o52, kbs_pkg::OP_CLR};
                7'd3:  e = '{6'o63, kbs_pkg::OP_KEEP, 1'b1, 6'o22, kbs_pkg::OP_CLR};
                7'd4:  e = '{6'o64, kbs_pkg::OP_KEEP, 1'b1, 6'o66, kbs_pkg::OP_CLR};
                7'd5:  e = '{6'o65, kbs_pkg::OP_KEEP, 1'b1, 6'o67, kbs_pkg::OP_CLR};
                7'd6:  e = '{6'o66, kbs_pkg::OP_KEEP, 1'b1, 6'o73, kbs_pkg::OP_CLR};
                7'd7:  e = '{6'o67, kbs_pkg::OP_KEEP, 1'b1, 6'o24, kbs_pkg::OP_CLR};
                7'd8:  e = '{6'o70, kbs_pkg::OP_KEEP, 1'b1, 6'o52, kbs_pkg::OP_CLR};
                7'd9:  e = '{6'o71, kbs_pkg::OP_KEEP, 1'b1, 6'o50, kbs_pkg::OP_KEEP};
                7'd36: e = '{6'o00, kbs_pkg::OP_KEEP, 1'b1, 6'o43, kbs_pkg::OP_KEEP};
                7'd37: e = '{6'o55, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd38: e = '{6'o10, kbs_pkg::OP_CLR,  1'b1, 6'o53, kbs_pkg::OP_KEEP};
                7'd39: e = '{6'o50, kbs_pkg::OP_CLR,  1'b1, 6'o17, kbs_pkg::OP_CLR};
                7'd40: e = '{6'o51, kbs_pkg::OP_CLR,  1'b1, 6'o20, kbs_pkg::OP_CLR};
                7'd41: e = '{6'o73, kbs_pkg::OP_SET,  1'b1, 6'o72, kbs_pkg::OP_SET};
                7'd42: e = '{6'o11, kbs_pkg::OP_CLR,  1'b1, 6'o31, kbs_pkg::OP_CLR};
                7'd43: e = '{6'o34, kbs_pkg::OP_SET,  1'b1, 6'o53, kbs_pkg::OP_CLR};
                7'd44: e = '{6'o34, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd45: e = '{6'o54, kbs_pkg::OP_SET,  1'b1, 6'o04, kbs_pkg::OP_CLR};
                7'd46: e = '{6'o56, kbs_pkg::OP_KEEP, 1'b1, 6'o06, kbs_pkg::OP_CLR};
                7'd47: e = '{6'o57, kbs_pkg::OP_KEEP, 1'b1, 6'o56, kbs_pkg::OP_CLR};
                7'd48: e = '{6'o42, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd49: e = '{6'o74, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd50: e = '{6'o44, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd51: e = '{6'o45, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd52: e = '{6'o33, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                7'd53: e = '{6'o40, kbs_pkg::OP_KEEP, 1'b0, 6'o00, kbs_pkg::OP_KEEP};
                default: ;
            endcase
        end
        return e;
    endfunction

    // Key event: modifier update or a new data word; returns whether it was taken
    function automatic logic key_taken(logic [6:0] key, logic [1:0] act);
        logic [3:0]       m;
        kbs_pkg::keymap_t e;
        logic [5:0]       code;
        kbs_pkg::top_op_t op;
        logic             shift_only;
        logic [12:0]      word;
        case (key)
            KEY_SHIFT_L, KEY_SHIFT_R, KEY_CAPS: m = kbs_pkg::MOD_SHIFT;
            KEY_CTRL_L, KEY_CTRL_R:             m = kbs_pkg::MOD_CTRL;
            KEY_META_L, KEY_META_R:             m = kbs_pkg::MOD_META;
            KEY_TOP_L, KEY_TOP_R:               m = kbs_pkg::MOD_TOP;
            default:                            m = 4'b0000;
        endcase
        if (m != 4'b0000) begin
            if (act == kbs_pkg::ACT_UP) begin
                mods_q = mods_q | m;
                return 1'b1;
            end
            if (act == kbs_pkg::ACT_DOWN) begin
                mods_q = mods_q & ~m;
                return 1'b1;
            end
            return 1'b0;
        end
        if (act == kbs_pkg::ACT_UP || 32'(key) >= kbs_pkg::NUM_KEYS) return 1'b0;

        e = char_entry(key);
        code = e.nc;
        op = e.nop;
        shift_only = (mods_q & (kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT)) == kbs_pkg::MOD_TOP;
        if (key == kbs_pkg::KEY_BACKSLASH) begin
            if (shift_only) begin
                code = CODE_BSL_SHIFT;
                op = kbs_pkg::OP_CLR;
            end else if ((mods_q & (kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT))
                         == kbs_pkg::MOD_SHIFT) begin
                op = kbs_pkg::OP_CLR;
            end else begin
                op = kbs_pkg::OP_SET;
            end
        end else if (key == kbs_pkg::KEY_C) begin
            // only control held
            if (mods_q == (kbs_pkg::MOD_META | kbs_pkg::MOD_TOP | kbs_pkg::MOD_SHIFT)) begin
                code = CODE_C_CTRL;
            end
        end else if (shift_only && e.has_alt) begin
            code = e.ac;
            op = e.aop;
        end

        word = {1'b1, 2'b00, mods_q, code};
        case (op)
            kbs_pkg::OP_CLR: word[kbs_pkg::WORD_TOP_BIT] = 1'b0;
            kbs_pkg::OP_SET: word[kbs_pkg::WORD_TOP_BIT] = 1'b1;
            default: ;
        endcase
        kword_q = word;
        status_q[kbs_pkg::ST_DONE] = 1'b1;
        if (level_q != 3'd0) irq_q = 1'b1;
        return 1'b1;
    endfunction

    // Expected result word for one request, advancing the predicted state
    function automatic kbs_pkg::out_word_t scan_predict(kbs_pkg::in_word_t w);
        kbs_pkg::out_word_t r;
        r = '0;
        case (w.req_type)
            kbs_pkg::REQ_STATUS_RD: r.read_data = {19'd0, status_q, level_q};
            kbs_pkg::REQ_CTRL_WR: begin
                level_q = w.bus_data[2:0];
                if (w.bus_data[kbs_pkg::CTRL_CLR_BIT]) status_q = 2'b00;
                irq_q = 1'b0;
            end
            kbs_pkg::REQ_DATA_RD: begin
                r.read_data = {line_q, 5'd0, kword_q};
                status_q = 2'b00;
                irq_q = 1'b0;
            end
            kbs_pkg::REQ_DATA_WR: begin
                if (w.bus_data[kbs_pkg::SPW_SEL_BIT]) begin
                    status_q[kbs_pkg::ST_SPW] = 1'b1;
                    line_q = w.bus_data[5:0];
                end
            end
            kbs_pkg::REQ_KEY: r.key_handled = key_taken(w.key_code, w.key_action);
            default: ;
        endcase
        r.irq_pending = irq_q;
        r.irq_level = irq_q ? level_q : 3'd0;
        return r;
    endfunction

    function automatic kbs_pkg::in_word_t make_word(logic [2:0] req, logic [12:0] data,
                                                    logic [6:0] key, logic [1:0] act);
        kbs_pkg::in_word_t w;
        w.req_type = req;
        w.bus_data = data;
        w.key_code = key;
        w.key_action = act;
        return w;
    endfunction

    // Typing mode gives mostly keys and register traffic; otherwise any field value
    function automatic kbs_pkg::in_word_t random_word(bit typing);
        kbs_pkg::in_word_t w;
        int unsigned       pick;
        w.req_type   = 3'($urandom_range(7, 0));
        w.bus_data   = 13'($urandom_range(8191, 0));
        w.key_code   = 7'($urandom_range(127, 0));
        w.key_action = 2'($urandom_range(3, 0));
        if (typing) begin
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                w.req_type = kbs_pkg::REQ_KEY;
                w.key_code = 7'($urandom_range(kbs_pkg::NUM_KEYS - 1, 0));
                w.key_action = ($urandom_range(3, 0) == 0) ? ACT_REPEAT : kbs_pkg::ACT_DOWN;
            end else if (pick < 66) begin
                w.req_type = kbs_pkg::REQ_KEY;
                w.key_code = 7'($urandom_range(KEY_TOP_R, KEY_SHIFT_L));
                w.key_action = ($urandom_range(1, 0) == 0) ? kbs_pkg::ACT_UP
                                                           : kbs_pkg::ACT_DOWN;
            end else if (pick < 78) begin
                w.req_type = kbs_pkg::REQ_DATA_RD;
            end else if (pick < 86) begin
                w.req_type = kbs_pkg::REQ_STATUS_RD;
            end else if (pick < 93) begin
                w.req_type = kbs_pkg::REQ_CTRL_WR;
            end else begin
                w.req_type = kbs_pkg::REQ_DATA_WR;
            end
        end
        return w;
    endfunction

    // Offer one word and hold it until accepted; valid stays up for the next call
    task automatic push_word(input kbs_pkg::in_word_t w);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(scan_predict(w));
    endtask

    // Stop sending until every predicted word has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_register_access();
        push_word(make_word(kbs_pkg::REQ_STATUS_RD, 13'h0000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_CTRL_WR, 13'h1FFF, KEY_MAX, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_DATA_WR, 13'h1FFF, KEY_MAX, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_STATUS_RD, 13'h1FFF, KEY_MAX, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_DATA_RD, 13'h0000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_DATA_WR, 13'h0FFF, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_DATA_WR, 13'h1000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_CTRL_WR, 13'h0000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(REQ_RSVD_LO, 13'h1FFF, KEY_MAX, ACT_ODD));
        push_word(make_word(REQ_RSVD_MID, 13'h1FFF, KEY_A, kbs_pkg::ACT_DOWN));
        push_word(make_word(REQ_RSVD_HI, 13'h1FFF, KEY_MAX, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_STATUS_RD, 13'h0000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
    endtask

    task automatic test_key_cases();
        // level zero: DONE without an interrupt
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_A, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_CTRL_WR, 13'h0005, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_DIGIT0, ACT_REPEAT));
        // shift only: alternate codes
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_SHIFT_L, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_DIGIT1, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, kbs_pkg::KEY_BACKSLASH,
                            kbs_pkg::ACT_DOWN));
        // shift and top held, then top only
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_TOP_L, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, kbs_pkg::KEY_BACKSLASH, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_SHIFT_L, kbs_pkg::ACT_UP));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, kbs_pkg::KEY_BACKSLASH,
                            kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_TOP_L, kbs_pkg::ACT_UP));
        // control only on the C key
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_CTRL_L, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, kbs_pkg::KEY_C, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_CTRL_L, kbs_pkg::ACT_UP));
        // words that are not taken
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_META_R, ACT_REPEAT));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_SHIFT_R, ACT_ODD));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_DIGIT5, kbs_pkg::ACT_UP));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h1FFF, KEY_MAX, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_KEY, 13'h0000, KEY_UNMAPPED, kbs_pkg::ACT_DOWN));
        push_word(make_word(kbs_pkg::REQ_DATA_RD, 13'h0000, KEY_DIGIT0, kbs_pkg::ACT_DOWN));
    endtask

    // Receiver stalls while the sender keeps offering, then a stretch with no idling
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold_req = 1'b1;
        repeat (24) push_word(random_word(1'b1));
        drain_results();
        repeat (200) push_word(random_word(1'b1));
        idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            push_word(random_word($urandom_range(99, 0) >= 12));
            if (i % 400 == 399) drain_results();
        end
    endtask

    // Result side: random stalls, plus the long hold when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on) begin
                m_ready <= ($urandom_range(99, 0) >= IDLE_PCT);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        kbs_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word %h with nothing expected", m_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, m_data.read_data);
                check_field("key_handled", 24'(want.key_handled), 24'(m_data.key_handled));
                check_field("irq_pending", 24'(want.irq_pending), 24'(m_data.irq_pending));
                check_field("irq_level", 24'(want.irq_level), 24'(m_data.irq_level));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** keyboard_scanner_registers: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        mods_q   = 4'b1111;
        kword_q  = '0;
        status_q = '0;
        level_q  = '0;
        line_q   = '0;
        irq_q    = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_key_cases();
        drain_results();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** keyboard_scanner_registers: PASSED **");
        end else begin
            $display("** keyboard_scanner_registers: FAILED **");
        end
        $finish;
    end

endmodule
